[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define TTE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define TTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/tte_pkg.sv]
package tte_pkg;

    localparam int SLOTS_DEF = 16;

    typedef enum logic [2:0] {
        ACT_CLEAR     = 3'd0,
        ACT_FIND      = 3'd1,
        ACT_ADD       = 3'd2,
        ACT_NEXT_PEND = 3'd3,
        ACT_FIND_SVC  = 3'd4,
        ACT_WR_OBJ    = 3'd5,
        ACT_WR_FILE   = 3'd6,
        ACT_UPDATE    = 3'd7
    } action_t;

    localparam logic [1:0] REG_WR_OBJ_LIST  = 2'd0;
    localparam logic [1:0] REG_WR_PROP_LIST = 2'd1;
    localparam logic [1:0] REG_WR_FILE      = 2'd2;

    localparam logic [7:0] RST_WR_OBJ_LIST  = 8'd0;
    localparam logic [7:0] RST_WR_PROP_LIST = 8'd1;
    localparam logic [7:0] RST_WR_FILE      = 8'd2;

    typedef struct packed {
        action_t     action;
        logic [15:0] peer_address;
        logic [7:0]  invoke_tag;
        logic [3:0]  slot_index;
        logic        has_self;
        logic [7:0]  service_code;
        logic [7:0]  object_kind;
        logic [7:0]  new_state;
        logic        new_svc_pending;
        logic        new_pdu_pending;
    } req_word_t;

    typedef struct packed {
        logic       found;
        logic [3:0] found_index;
        logic [4:0] free_count;
    } rsp_word_t;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] value;
    } cfg_word_t;

    typedef struct packed {
        logic [7:0] wr_obj_list;
        logic [7:0] wr_prop_list;
        logic [7:0] wr_file;
    } cfg_codes_t;

    typedef struct packed {
        logic [7:0] state;
        logic       svc_pending;
        logic       pdu_pending;
    } slot_stat_t;

    typedef struct packed {
        logic [15:0] peer;
        logic [7:0]  invoke;
        logic [7:0]  service;
        logic [7:0]  object;
    } slot_data_t;

    typedef struct packed {
        logic scanning;
        logic writing;
    } seq_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_DONE  = 4'b1000
    } seq_state_t;

endpackage

[src/tte_if.sv]
interface tte_req_if import tte_pkg::*; ();
    logic      valid;
    logic      ready;
    req_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tte_rsp_if import tte_pkg::*; ();
    logic      valid;
    logic      ready;
    rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tte_cfg_if import tte_pkg::*; ();
    logic      valid;
    logic      ready;
    cfg_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/tte_ram.sv]
module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/tte_cfg.sv]
module tte_cfg import tte_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    tte_cfg_if.sink    cfg,
    output cfg_codes_t codes
);

    cfg_codes_t codes_reg;

    assign cfg.ready = 1'b1;
    assign codes     = codes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.wr_obj_list  <= RST_WR_OBJ_LIST;
            codes_reg.wr_prop_list <= RST_WR_PROP_LIST;
            codes_reg.wr_file      <= RST_WR_FILE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_WR_OBJ_LIST:  codes_reg.wr_obj_list  <= cfg.data.value;
                REG_WR_PROP_LIST: codes_reg.wr_prop_list <= cfg.data.value;
                REG_WR_FILE:      codes_reg.wr_file      <= cfg.data.value;
                default:          ;
            endcase
        end
    end

endmodule

[src/tte_seq.sv]
module tte_seq import tte_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_codes_t codes,
    tte_req_if.sink    req,
    tte_rsp_if.source  rsp,
    output seq_stat_t  stat
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    seq_state_t        state_reg, state_next;
    req_word_t         op_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [CW-1:0]     idle_cnt_reg;
    logic [CW-1:0]     issue_cnt_reg;
    logic [IW-1:0]     addr_reg;
    logic              pend_reg;
    logic [IW-1:0]     pend_addr_reg;
    logic              vbit_reg;
    logic              idx_ok_reg;
    logic              hit_reg;
    logic [IW-1:0]     hit_addr_reg;
    slot_stat_t        hit_stat_reg;
    slot_data_t        hit_data_reg;
    logic              out_valid_reg;
    rsp_word_t         out_reg;

    slot_stat_t        stat_rd;
    slot_data_t        data_rd;
    slot_stat_t        eff_stat;
    slot_stat_t        stat_wr;
    slot_data_t        data_wr;
    logic              busy;
    logic              is_self;
    logic              svc_ok_obj;
    logic              match;
    logic              issuing;
    logic [CW-1:0]     total;
    logic              scan_end;
    logic              accept;
    logic              load_out;
    logic              stat_we;
    logic              data_we;
    logic              new_busy;
    logic              idx_ok_in;
    logic [4:0]        nxt_start;
    logic [IW-1:0]     start_addr;

    tte_ram #(.WIDTH($bits(slot_stat_t)), .DEPTH(SLOTS)) u_stat_ram (
        .clk   (clk),
        .we    (stat_we),
        .waddr (hit_addr_reg),
        .wdata (stat_wr),
        .re    (issuing),
        .raddr (addr_reg),
        .rdata (stat_rd)
    );

    tte_ram #(.WIDTH($bits(slot_data_t)), .DEPTH(SLOTS)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (hit_addr_reg),
        .wdata (data_wr),
        .re    (issuing),
        .raddr (addr_reg),
        .rdata (data_rd)
    );

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
    assign stat.scanning = (state_reg == ST_SCAN);
    assign stat.writing  = (state_reg == ST_WRITE);

    assign idx_ok_in  = 32'(req.data.slot_index) < SLOTS;
    assign nxt_start  = {1'b0, req.data.slot_index} + 5'd1;

    always_comb
    begin
        if (req.data.action == ACT_NEXT_PEND)
        begin
            start_addr = (32'(nxt_start) >= SLOTS) ? '0 : IW'(nxt_start);
        end
        else if (req.data.action == ACT_UPDATE)
        begin
            start_addr = IW'(req.data.slot_index);
        end
        else
        begin
            start_addr = '0;
        end
    end

    assign total    = (op_reg.action == ACT_UPDATE) ? CW'(1) : CW'(SLOTS);
    assign issuing  = (state_reg == ST_SCAN) && (issue_cnt_reg != total);
    assign scan_end = (state_reg == ST_SCAN) && (issue_cnt_reg == total) && !pend_reg;

    // Slots that were cleared or never updated read back as idle.
    assign eff_stat = vbit_reg ? stat_rd : '0;
    assign busy     = (eff_stat.state != '0) || eff_stat.svc_pending || eff_stat.pdu_pending;
    assign is_self  = op_reg.has_self && idx_ok_reg && (pend_addr_reg == IW'(op_reg.slot_index));
    assign svc_ok_obj = (data_rd.service == codes.wr_obj_list)
                     || (data_rd.service == codes.wr_prop_list);

    always_comb
    begin
        unique case (op_reg.action)
            ACT_CLEAR:     match = 1'b0;
            ACT_FIND:      match = (eff_stat.state != '0)
                                && (data_rd.peer == op_reg.peer_address)
                                && (data_rd.invoke == op_reg.invoke_tag);
            ACT_ADD:       match = !busy;
            ACT_NEXT_PEND: match = eff_stat.pdu_pending;
            ACT_FIND_SVC:  match = busy && (data_rd.service == op_reg.service_code);
            ACT_WR_OBJ:    match = !is_self && busy && svc_ok_obj
                                && (data_rd.object == op_reg.object_kind);
            ACT_WR_FILE:   match = !is_self && busy
                                && (data_rd.service == codes.wr_file)
                                && (data_rd.object == op_reg.object_kind);
            ACT_UPDATE:    match = idx_ok_reg;
            default:       match = 1'b0;
        endcase
    end

    assign new_busy = (op_reg.new_state != '0) || op_reg.new_svc_pending
                   || op_reg.new_pdu_pending;

    assign stat_we = (state_reg == ST_WRITE) && (op_reg.action == ACT_UPDATE);
    assign data_we = (state_reg == ST_WRITE);

    assign stat_wr.state       = op_reg.new_state;
    assign stat_wr.svc_pending = op_reg.new_svc_pending;
    assign stat_wr.pdu_pending = op_reg.new_pdu_pending;

    always_comb
    begin
        if (op_reg.action == ACT_UPDATE)
        begin
            data_wr.peer    = hit_data_reg.peer;
            data_wr.invoke  = hit_data_reg.invoke;
            data_wr.service = op_reg.service_code;
            data_wr.object  = op_reg.object_kind;
        end
        else
        begin
            data_wr.peer    = op_reg.peer_address;
            data_wr.invoke  = op_reg.invoke_tag;
            data_wr.service = hit_data_reg.service;
            data_wr.object  = '0;
        end
    end

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.data.action == ACT_CLEAR) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    if (hit_reg && (op_reg.action == ACT_ADD || op_reg.action == ACT_UPDATE))
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            idle_cnt_reg  <= CW'(SLOTS);
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issuing;

            if (accept)
            begin
                issue_cnt_reg <= '0;
                hit_reg       <= 1'b0;
                if (req.data.action == ACT_CLEAR)
                begin
                    valid_reg    <= '0;
                    idle_cnt_reg <= CW'(SLOTS);
                end
            end
            else if (issuing)
            begin
                issue_cnt_reg <= issue_cnt_reg + CW'(1);
            end

            if (pend_reg && match && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end

            if (stat_we)
            begin
                valid_reg[hit_addr_reg] <= 1'b1;
                if (hit_stat_reg.state != '0 || hit_stat_reg.svc_pending
                    || hit_stat_reg.pdu_pending)
                begin
                    if (!new_busy)
                    begin
                        idle_cnt_reg <= idle_cnt_reg + CW'(1);
                    end
                end
                else if (new_busy)
                begin
                    idle_cnt_reg <= idle_cnt_reg - CW'(1);
                end
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.data;
            addr_reg   <= start_addr;
            idx_ok_reg <= idx_ok_in;
        end
        else if (issuing)
        begin
            addr_reg <= (addr_reg == IW'(SLOTS - 1)) ? '0 : addr_reg + IW'(1);
        end

        if (issuing)
        begin
            pend_addr_reg <= addr_reg;
            vbit_reg      <= valid_reg[addr_reg];
        end

        if (pend_reg && match && !hit_reg)
        begin
            hit_addr_reg <= pend_addr_reg;
            hit_stat_reg <= eff_stat;
            hit_data_reg <= data_rd;
        end

        if (load_out)
        begin
            out_reg.found       <= hit_reg;
            out_reg.found_index <= hit_reg ? 4'(hit_addr_reg) : 4'd0;
            out_reg.free_count  <= 5'(idle_cnt_reg);
        end
    end

endmodule

[src/transaction_table_engine.sv]
// Channel  Role    Word         Meaning
// cfg      sink    cfg_word_t   service code registers, index and value
// req      sink    req_word_t   one table operation
// rsp      source  rsp_word_t   found flag, slot index and idle count
//
// A search reads the slot memories once per slot, and an add that finds an idle slot
// then writes it back; an update reads only its target slot, and a clear reads none.
// A new word is taken once the result of the previous one is registered for output.
// Reset returns every slot to idle and loads the default service codes.
// A stalled result holds its output register; the sequencer waits in its final step.
`include "assert_macros.svh"

module transaction_table_engine import tte_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tte_cfg_if.sink   cfg,
    tte_req_if.sink   req,
    tte_rsp_if.source rsp
);

    cfg_codes_t codes;
    seq_stat_t  seq_stat;

    tte_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .codes (codes)
    );

    tte_seq #(.SLOTS(SLOTS)) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .codes (codes),
        .req   (req),
        .rsp   (rsp),
        .stat  (seq_stat)
    );

    `TTE_ASSERT_IMPL(a_busy_blocks_req, seq_stat.scanning || seq_stat.writing, !req.ready, "request taken while an operation is in progress")
    `TTE_ASSERT_NEXT(a_one_word_at_a_time, req.valid && req.ready, !req.ready, "second request taken right after the first")
    `TTE_ASSERT_IMPL(a_miss_index_zero, rsp.valid && !rsp.data.found, rsp.data.found_index == 4'd0, "miss reported with a nonzero slot index")

endmodule
